/* src/qsu_pkg.sv */
// ----------------------------------------------------------------------------
// qsu_pkg: shared types and constants of the quoted string unescape parser
// Holds the parse phase encoding, status codes, character codes and the
// result record that passes from the decoder to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package qsu_pkg;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_FIELD = 2'd1,
		PH_ESC   = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_DATA     = 3'd0,
		ST_DONE     = 3'd1,
		ST_NO_OPEN  = 3'd2,
		ST_BAD_CHAR = 3'd3,
		ST_NO_CLOSE = 3'd4
	} status_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef struct packed {
		logic [7:0] data;
		status_t    status;
		logic       field_end;
	} result_t;

endpackage

`default_nettype wire

/* src/qsu_decode.sv */
// ----------------------------------------------------------------------------
// qsu_decode: phase machine of the parser
// From the current phase and one byte, works out the next phase and whether
// a result is produced, together with its contents.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_decode (
	input  wire qsu_pkg::phase_t  phase,
	input  wire logic [7:0]       in_data,
	output qsu_pkg::phase_t       phase_next,
	output logic                  emit,
	output qsu_pkg::result_t      result
);
	import qsu_pkg::*;

	status_t    st;
	logic [7:0] data;

	always_comb begin
		phase_next = PH_IDLE;
		case (phase)
			PH_FIELD: begin
				if (in_data == CH_BSLASH) begin
					phase_next = PH_ESC;
				end else if (in_data inside {CH_NUL, CH_SEMI, CH_COLON, CH_QUOTE}) begin
					phase_next = PH_IDLE;
				end else begin
					phase_next = PH_FIELD;
				end
			end
			PH_ESC: begin
				phase_next = (in_data == CH_NUL) ? PH_IDLE : PH_FIELD;
			end
			default: begin
				phase_next = (in_data == CH_QUOTE) ? PH_FIELD : PH_IDLE;
			end
		endcase
	end

	always_comb begin
		emit = 1'b1;
		st   = ST_DATA;
		data = 8'h00;
		case (phase)
			PH_FIELD: begin
				if (in_data == CH_NUL) begin
					st = ST_NO_CLOSE;
				end else if (in_data == CH_BSLASH) begin
					emit = 1'b0;
				end else if (in_data inside {CH_SEMI, CH_COLON}) begin
					st = ST_BAD_CHAR;
				end else if (in_data == CH_QUOTE) begin
					st = ST_DONE;
				end else begin
					data = in_data;
				end
			end
			PH_ESC: begin
				if (in_data == CH_NUL) begin
					st = ST_NO_CLOSE;
				end else if (in_data == CH_N) begin
					data = CH_LF;
				end else if (in_data == CH_R) begin
					data = CH_CR;
				end else begin
					data = in_data;
				end
			end
			default: begin
				if (in_data == CH_QUOTE) begin
					emit = 1'b0;
				end else begin
					st = ST_NO_OPEN;
				end
			end
		endcase
		result.data      = data;
		result.status    = st;
		result.field_end = (st != ST_DATA);
	end

endmodule

`default_nettype wire

/* src/qsu_out_stage.sv */
// ----------------------------------------------------------------------------
// qsu_out_stage: result register of the parser
// Holds one result until the output transfer completes and reports whether a
// new result may be loaded in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire qsu_pkg::result_t load_result,
	output logic                  can_load,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output qsu_pkg::result_t      out_result
);
	import qsu_pkg::*;

	logic    valid_q;
	result_t result_q;

	assign can_load   = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= load_result;
		end
	end

endmodule

`default_nettype wire

/* src/quoted_string_unescape_parser.sv */
// ----------------------------------------------------------------------------
// quoted_string_unescape_parser: backslash-escaped quoted string decoder
// Registers each input byte, decodes it against the parse phase and places
// any result in an output register.
// ----------------------------------------------------------------------------
// The parser takes one byte per cycle while no output stall holds it, and
// gives at most one result per byte; a byte passes through the input
// register and then the result register. The phase update lets bytes
// follow each other in consecutive cycles; an opening quote or a backslash
// gives no result. Output stalls propagate back to the input only when the
// result register is full and not being taken.
`default_nettype none

module quoted_string_unescape_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic [2:0]      status,
	output logic            field_end
);
	import qsu_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	phase_t     phase_q;
	phase_t     phase_next;
	logic       emit;
	result_t    dec_result;
	logic       can_load;
	logic       advance;
	result_t    out_result;

	qsu_decode u_decode (
		.phase      (phase_q),
		.in_data    (byte_s1),
		.phase_next (phase_next),
		.emit       (emit),
		.result     (dec_result)
	);

	assign advance  = valid_s1 && (!emit || can_load);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_IDLE;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				phase_q <= phase_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	qsu_out_stage u_out_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && emit),
		.load_result (dec_result),
		.can_load    (can_load),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_result  (out_result)
	);

	assign out_byte  = out_result.data;
	assign status    = out_result.status;
	assign field_end = out_result.field_end;

endmodule

`default_nettype wire
